### sv/gga_sentence_field_extractor_assert.svh
// Assertion macros used by the checker file of the GGA field extractor.
`ifndef GGA_SENTENCE_FIELD_EXTRACTOR_ASSERT_SVH
`define GGA_SENTENCE_FIELD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define GSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gse assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define GSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gse assertion failed");

`endif

### sv/gse_pkg.sv
// Types and constants of the GGA sentence field extractor.
package gse_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [2:0] CODE_TIME = 3'd0;
  localparam logic [2:0] CODE_LAT  = 3'd1;
  localparam logic [2:0] CODE_NS   = 3'd2;
  localparam logic [2:0] CODE_LON  = 3'd3;
  localparam logic [2:0] CODE_EW   = 3'd4;
  localparam logic [2:0] CODE_END  = 3'd5;

  // Body positions of the fields.
  localparam int HDR_LEN     = 5;
  localparam int TIME_FIRST  = 6;
  localparam int TIME_LEN    = 10;
  localparam int LAT_FIRST   = 17;
  localparam int LAT_LEN     = 9;
  localparam int NS_POS      = 27;
  localparam int LON_FIRST   = 29;
  localparam int LON_LEN     = 10;
  localparam int EW_POS      = 40;

  typedef struct packed {
    logic [2:0] field_code;
    logic [7:0] char_value;
    logic       last;
  } res_t;

  // Expected header text "GPGGA" by body position.
  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h47;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### sv/gse_parser.sv
// Sentence tracking state and per-byte field decode of the GGA extractor.
module gse_parser #(
  parameter int MAX_SENTENCE = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  output logic            res_valid,
  output gse_pkg::res_t   res
);
  import gse_pkg::*;

  localparam int PW = $clog2(MAX_SENTENCE);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_SENTENCE - 1);
  localparam logic [PW-1:0] P_HDR   = PW'(HDR_LEN);
  localparam logic [PW-1:0] P_TIME0 = PW'(TIME_FIRST);
  localparam logic [PW-1:0] P_TIME1 = PW'(TIME_FIRST + TIME_LEN);
  localparam logic [PW-1:0] P_LAT0  = PW'(LAT_FIRST);
  localparam logic [PW-1:0] P_LAT1  = PW'(LAT_FIRST + LAT_LEN);
  localparam logic [PW-1:0] P_NS    = PW'(NS_POS);
  localparam logic [PW-1:0] P_LON0  = PW'(LON_FIRST);
  localparam logic [PW-1:0] P_LON1  = PW'(LON_FIRST + LON_LEN);
  localparam logic [PW-1:0] P_EW    = PW'(EW_POS);

  logic          in_sentence, in_sentence_next;
  logic [PW-1:0] pos, pos_next;
  logic          header_match, header_match_next;
  logic          time_open, time_open_next;
  logic          lat_open, lat_open_next;
  logic          lon_open, lon_open_next;

  always_comb begin
    in_sentence_next  = in_sentence;
    pos_next          = pos;
    header_match_next = header_match;
    time_open_next    = time_open;
    lat_open_next     = lat_open;
    lon_open_next     = lon_open;
    res_valid         = 1'b0;
    res               = '0;
    if (accept) begin
      if (!in_sentence) begin
        if (rx_byte == CH_DOLLAR) begin
          in_sentence_next  = 1'b1;
          pos_next          = '0;
          header_match_next = 1'b1;
          time_open_next    = 1'b1;
          lat_open_next     = 1'b1;
          lon_open_next     = 1'b1;
        end
      end else if (rx_byte == CH_STAR) begin
        res_valid         = 1'b1;
        res.field_code    = CODE_END;
        res.last          = header_match && (pos >= P_HDR);
        in_sentence_next  = 1'b0;
        pos_next          = '0;
        header_match_next = 1'b1;
        time_open_next    = 1'b1;
        lat_open_next     = 1'b1;
        lon_open_next     = 1'b1;
      end else begin
        if (pos < P_HDR) begin
          if (rx_byte != header_char(pos[2:0])) begin
            header_match_next = 1'b0;
          end
        end else if (header_match) begin
          res.char_value = rx_byte;
          if (pos == P_NS) begin
            res_valid      = 1'b1;
            res.field_code = CODE_NS;
          end else if (pos == P_EW) begin
            res_valid      = 1'b1;
            res.field_code = CODE_EW;
          end else if (pos < P_LAT0) begin
            if (pos >= P_TIME0 && pos < P_TIME1 && time_open) begin
              if (rx_byte == CH_COMMA) begin
                time_open_next = 1'b0;
              end else begin
                res_valid      = 1'b1;
                res.field_code = CODE_TIME;
              end
            end
          end else if (pos < P_NS) begin
            if (pos < P_LAT1 && lat_open) begin
              if (rx_byte == CH_COMMA) begin
                lat_open_next = 1'b0;
              end else begin
                res_valid      = 1'b1;
                res.field_code = CODE_LAT;
              end
            end
          end else begin
            if (pos >= P_LON0 && pos < P_LON1 && lon_open) begin
              if (rx_byte == CH_COMMA) begin
                lon_open_next = 1'b0;
              end else begin
                res_valid      = 1'b1;
                res.field_code = CODE_LON;
              end
            end
          end
        end
        // The position holds at the last slot so long sentences stay out of every field.
        if (pos < POS_MAX) begin
          pos_next = pos + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence  <= 1'b0;
      pos          <= '0;
      header_match <= 1'b1;
      time_open    <= 1'b1;
      lat_open     <= 1'b1;
      lon_open     <= 1'b1;
    end else begin
      in_sentence  <= in_sentence_next;
      pos          <= pos_next;
      header_match <= header_match_next;
      time_open    <= time_open_next;
      lat_open     <= lat_open_next;
      lon_open     <= lon_open_next;
    end
  end

endmodule

### sv/gse_out_reg.sv
// Result register with a skid stage between the decoder and the output channel.
module gse_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  gse_pkg::res_t up_data,
  output logic          full,
  output logic          dn_valid,
  input  logic          dn_stall,
  output gse_pkg::res_t dn_data
);
  import gse_pkg::*;

  logic skid_valid;
  res_t skid_data;

  // While the skid entry is occupied the input side is stalled, so no beat is lost.
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!dn_valid || !dn_stall) begin
      if (skid_valid) begin
        dn_valid   <= 1'b1;
        dn_data    <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        dn_valid <= up_valid;
        if (up_valid) begin
          dn_data <= up_data;
        end
      end
    end else if (up_valid) begin
      skid_valid <= 1'b1;
      skid_data  <= up_data;
    end
  end

endmodule

### sv/gga_sentence_field_extractor.sv
// Top level of the GGA sentence field extractor.
// Usage:
//   The input channel (in_valid, in_stall, rx_byte) takes one received
//   serial character per beat. Bytes are ignored until '$'; the body that
//   follows, up to '*', is checked for the GPGGA header.
//   The output channel (out_valid, out_stall, field_code, char_value, last)
//   carries one beat per extracted character of the time, latitude,
//   north/south, longitude and east/west fields, and one end-of-record beat
//   per '*' closing a sentence (last is high when the sentence was GGA).
//   Most input beats produce no output beat.
// Result path and throughput:
//   A result is registered once its input beat is accepted. One byte is
//   accepted every cycle while in_stall is low; the figure is set by the
//   single decode step between the sentence state and the result register.
// Stalls and reset:
//   While out_stall holds a result, one more result is parked in a skid
//   register; only then is in_stall raised. Reset clears the sentence
//   state and empties both result registers.
module gga_sentence_field_extractor #(
  parameter int MAX_SENTENCE = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] field_code,
  output logic [7:0] char_value,
  output logic       last
);
  import gse_pkg::*;

  logic accept;
  logic res_valid;
  res_t res;
  res_t out_data;

  assign accept = in_valid && !in_stall;

  gse_parser #(
    .MAX_SENTENCE(MAX_SENTENCE)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  gse_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .up_valid(res_valid),
    .up_data (res),
    .full    (in_stall),
    .dn_valid(out_valid),
    .dn_stall(out_stall),
    .dn_data (out_data)
  );

  assign field_code = out_data.field_code;
  assign char_value = out_data.char_value;
  assign last       = out_data.last;

endmodule

### sv/gse_checker.sv
// Port-level checker for the GGA sentence field extractor and its bind.
`include "gga_sentence_field_extractor_assert.svh"

module gse_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] field_code,
  input logic [7:0] char_value,
  input logic       last
);
  import gse_pkg::*;

  // Only the end-of-record beat may carry last.
  `GSE_ASSERT_NOW(a_last_on_end, out_valid && last, field_code == CODE_END)
  // The end-of-record beat carries no character.
  `GSE_ASSERT_NOW(a_end_zero, out_valid && field_code == CODE_END, char_value == 8'h00)
  // The input side stalls only while a result is held back by the output side.
  `GSE_ASSERT_NOW(a_stall_cause, in_stall, out_valid && $past(out_valid && out_stall))
  // A stalled output beat stays offered.
  `GSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind gga_sentence_field_extractor gse_checker u_gse_checker (.*);
